/* src/saam_pkg.sv */
// ----------------------------------------------------------------------------
// saam_pkg
// Shared widths, register map and helpers for the strided argmin/argmax block.
// ----------------------------------------------------------------------------
package saam_pkg;

  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned OFFSET_WIDTH = 32;
  localparam int unsigned EXTENT_WIDTH = 16;

  localparam int unsigned DATA_WIDTH   = 32;
  localparam int unsigned NUM_REGS     = 8;
  localparam int unsigned REG_IDX_W    = $clog2(NUM_REGS);
  localparam int unsigned ADDR_WIDTH   = REG_IDX_W + 2;

  localparam logic [EXTENT_WIDTH:0] EXT_MAX = (EXTENT_WIDTH + 1)'(1) << EXTENT_WIDTH;
  localparam logic [EXTENT_WIDTH:0] EXT_ONE = (EXTENT_WIDTH + 1)'(1);

  typedef enum logic [1:0] {
    MODE_FIRST_MIN = 2'd0,
    MODE_FIRST_MAX = 2'd1,
    MODE_LAST_MIN  = 2'd2,
    MODE_LAST_MAX  = 2'd3
  } mode_e;

  localparam logic [REG_IDX_W-1:0] REG_MODE          = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_EXTENT_INNER  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_EXTENT_MIDDLE = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_EXTENT_OUTER  = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_STRIDE_INNER  = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_STRIDE_MIDDLE = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_STRIDE_OUTER  = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_STRIDE_TOP    = REG_IDX_W'(7);

  // Zero acts as one, anything above the counter range saturates.
  function automatic logic [EXTENT_WIDTH:0] eff_extent(input logic [EXTENT_WIDTH:0] e);
    logic [EXTENT_WIDTH:0] r;
    r = e;
    if (e == '0) begin
      r = EXT_ONE;
    end else if (e > EXT_MAX) begin
      r = EXT_MAX;
    end
    return r;
  endfunction

endpackage

/* src/strided_argmin_argmax.sv */
// ----------------------------------------------------------------------------
// strided_argmin_argmax
// Streaming argmin/argmax over a strided 4-D set with computed memory offsets.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// in       sink       in_valid_i / in_stall_o  sample_i, last_in_set_i
// out      source     out_valid_o / out_stall_i best_offset_o, best_value_o
// cfg      APB slave  psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// One transaction per cycle while in_stall_o is low; the last element of a
// set passes capture, stride multiply and compare/offset add to its result.
// Throughput is set by the three-stage pipe; each stage holds one element.
// Reset clears counters, best value, pipe valids and loads register defaults.
// A stalled result holds an element marked last and those behind it only.
// ----------------------------------------------------------------------------
module strided_argmin_argmax
  import saam_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] sample_i,
  input  logic                         last_in_set_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [OFFSET_WIDTH-1:0]      best_offset_o,
  output logic signed [VALUE_WIDTH-1:0] best_value_o,

  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_WIDTH-1:0]        paddr,
  input  logic [DATA_WIDTH-1:0]        pwdata,
  output logic [DATA_WIDTH-1:0]        prdata,
  output logic                         pready
);

  // configuration
  logic [1:0]              mode_q;
  logic [EXTENT_WIDTH:0]   ext_in_q, ext_mid_q, ext_out_q;
  logic [OFFSET_WIDTH-1:0] str_in_q, str_mid_q, str_out_q, str_top_q;
  logic [REG_IDX_W-1:0]    reg_idx;
  logic                    cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_WIDTH-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_FIRST_MIN;
      ext_in_q  <= EXT_ONE;
      ext_mid_q <= EXT_ONE;
      ext_out_q <= EXT_ONE;
      str_in_q  <= OFFSET_WIDTH'(1);
      str_mid_q <= '0;
      str_out_q <= '0;
      str_top_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODE:          mode_q    <= pwdata[1:0];
        REG_EXTENT_INNER:  ext_in_q  <= pwdata[EXTENT_WIDTH:0];
        REG_EXTENT_MIDDLE: ext_mid_q <= pwdata[EXTENT_WIDTH:0];
        REG_EXTENT_OUTER:  ext_out_q <= pwdata[EXTENT_WIDTH:0];
        REG_STRIDE_INNER:  str_in_q  <= pwdata[OFFSET_WIDTH-1:0];
        REG_STRIDE_MIDDLE: str_mid_q <= pwdata[OFFSET_WIDTH-1:0];
        REG_STRIDE_OUTER:  str_out_q <= pwdata[OFFSET_WIDTH-1:0];
        REG_STRIDE_TOP:    str_top_q <= pwdata[OFFSET_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_MODE:          prdata = DATA_WIDTH'(mode_q);
      REG_EXTENT_INNER:  prdata = DATA_WIDTH'(ext_in_q);
      REG_EXTENT_MIDDLE: prdata = DATA_WIDTH'(ext_mid_q);
      REG_EXTENT_OUTER:  prdata = DATA_WIDTH'(ext_out_q);
      REG_STRIDE_INNER:  prdata = DATA_WIDTH'(str_in_q);
      REG_STRIDE_MIDDLE: prdata = DATA_WIDTH'(str_mid_q);
      REG_STRIDE_OUTER:  prdata = DATA_WIDTH'(str_out_q);
      REG_STRIDE_TOP:    prdata = DATA_WIDTH'(str_top_q);
      default:           prdata = '0;
    endcase
  end

  // pipe control
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_last_q, s2_last_q;
  logic in_acc, mv1, ld2, en2, out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign en2        = s2_valid_q && (!s2_last_q || out_free);
  assign ld2        = !s2_valid_q || en2;
  assign mv1        = s1_valid_q && ld2;
  assign in_stall_o = s1_valid_q && !ld2;
  assign in_acc     = in_valid_i && !in_stall_o;

  // index counters
  logic [EXTENT_WIDTH-1:0] cnt_in_q, cnt_mid_q, cnt_out_q;
  logic [EXTENT_WIDTH-1:0] cnt_in_d, cnt_mid_d, cnt_out_d;
  logic [OFFSET_WIDTH-1:0] run_off_q, run_off_d;
  logic [EXTENT_WIDTH:0]   inc_in, inc_mid, inc_out;
  logic                    wrap_in, wrap_mid, wrap_out;

  always_comb begin
    inc_in   = {1'b0, cnt_in_q} + EXT_ONE;
    inc_mid  = {1'b0, cnt_mid_q} + EXT_ONE;
    inc_out  = {1'b0, cnt_out_q} + EXT_ONE;
    wrap_in  = inc_in >= eff_extent(ext_in_q);
    wrap_mid = inc_mid >= eff_extent(ext_mid_q);
    wrap_out = inc_out >= eff_extent(ext_out_q);
    cnt_in_d  = wrap_in ? '0 : inc_in[EXTENT_WIDTH-1:0];
    cnt_mid_d = cnt_mid_q;
    cnt_out_d = cnt_out_q;
    run_off_d = run_off_q;
    if (wrap_in) begin
      cnt_mid_d = wrap_mid ? '0 : inc_mid[EXTENT_WIDTH-1:0];
      if (wrap_mid) begin
        cnt_out_d = wrap_out ? '0 : inc_out[EXTENT_WIDTH-1:0];
        if (wrap_out) begin
          run_off_d = run_off_q + str_top_q;
        end
      end
    end
    if (last_in_set_i) begin
      cnt_in_d  = '0;
      cnt_mid_d = '0;
      cnt_out_d = '0;
      run_off_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_in_q  <= '0;
      cnt_mid_q <= '0;
      cnt_out_q <= '0;
      run_off_q <= '0;
    end else if (in_acc) begin
      cnt_in_q  <= cnt_in_d;
      cnt_mid_q <= cnt_mid_d;
      cnt_out_q <= cnt_out_d;
      run_off_q <= run_off_d;
    end
  end

  // stage 1: captured element and its indices
  logic signed [VALUE_WIDTH-1:0] s1_sample_q;
  logic [EXTENT_WIDTH-1:0]       s1_cin_q, s1_cmid_q, s1_cout_q;
  logic [OFFSET_WIDTH-1:0]       s1_run_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= sample_i;
      s1_last_q   <= last_in_set_i;
      s1_cin_q    <= cnt_in_q;
      s1_cmid_q   <= cnt_mid_q;
      s1_cout_q   <= cnt_out_q;
      s1_run_q    <= run_off_q;
    end
  end

  // stage 2: stride products
  logic signed [VALUE_WIDTH-1:0] s2_sample_q;
  logic [OFFSET_WIDTH-1:0]       s2_p_in_q, s2_p_mid_q, s2_p_out_q, s2_run_q;
  logic [OFFSET_WIDTH-1:0]       p_in, p_mid, p_out;

  assign p_in  = OFFSET_WIDTH'(s1_cin_q) * str_in_q;
  assign p_mid = OFFSET_WIDTH'(s1_cmid_q) * str_mid_q;
  assign p_out = OFFSET_WIDTH'(s1_cout_q) * str_out_q;

  always_ff @(posedge clk_i) begin
    if (mv1) begin
      s2_sample_q <= s1_sample_q;
      s2_last_q   <= s1_last_q;
      s2_p_in_q   <= p_in;
      s2_p_mid_q  <= p_mid;
      s2_p_out_q  <= p_out;
      s2_run_q    <= s1_run_q;
    end
  end

  // stage 3: offset sum, compare, best update
  logic signed [VALUE_WIDTH-1:0] held_value_q, nxt_value;
  logic [OFFSET_WIDTH-1:0]       held_offset_q, nxt_offset, cur_offset;
  logic                          seen_any_q, take;
  logic [OFFSET_WIDTH-1:0]       out_offset_q;
  logic signed [VALUE_WIDTH-1:0] out_value_q;

  always_comb begin
    cur_offset = s2_run_q + s2_p_out_q + s2_p_mid_q + s2_p_in_q;
    case (mode_q)
      MODE_FIRST_MIN: take = held_value_q >  s2_sample_q;
      MODE_FIRST_MAX: take = held_value_q <  s2_sample_q;
      MODE_LAST_MIN:  take = held_value_q >= s2_sample_q;
      MODE_LAST_MAX:  take = held_value_q <= s2_sample_q;
      default:        take = 1'b0;
    endcase
    if (!seen_any_q) begin
      nxt_value  = s2_sample_q;
      nxt_offset = '0;
    end else if (take) begin
      nxt_value  = s2_sample_q;
      nxt_offset = cur_offset;
    end else begin
      nxt_value  = held_value_q;
      nxt_offset = held_offset_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_value_q  <= '0;
      held_offset_q <= '0;
      seen_any_q    <= 1'b0;
    end else if (en2) begin
      if (s2_last_q) begin
        held_value_q  <= '0;
        held_offset_q <= '0;
        seen_any_q    <= 1'b0;
      end else begin
        held_value_q  <= nxt_value;
        held_offset_q <= nxt_offset;
        seen_any_q    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && s2_last_q) begin
      out_offset_q <= nxt_offset;
      out_value_q  <= nxt_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (mv1) begin
        s1_valid_q <= 1'b0;
      end
      if (mv1) begin
        s2_valid_q <= 1'b1;
      end else if (en2) begin
        s2_valid_q <= 1'b0;
      end
      if (en2 && s2_last_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign best_offset_o = out_offset_q;
  assign best_value_o  = out_value_q;

endmodule

/* tb/tb_strided_argmin_argmax.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_strided_argmin_argmax
// Self-checking bench for the strided argmin/argmax block. A scoreboard model
// tracks the nested element counters, the memory offsets and the winner of
// each set under the current mode and layout, and every result transaction is
// compared with the oldest prediction. Directed sets cover the register
// defaults, all four modes with ties at the value extremes and the extent
// limits. Random layouts and tie-heavy data then run under sender and
// receiver backpressure, and once with neither.
// ----------------------------------------------------------------------------
module tb_strided_argmin_argmax;
  import saam_pkg::*;

  typedef struct packed {
    logic [OFFSET_WIDTH-1:0]       offset;
    logic signed [VALUE_WIDTH-1:0] value;
  } winner_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic signed [VALUE_WIDTH-1:0] sample_i;
  logic                          last_in_set_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [OFFSET_WIDTH-1:0]       best_offset_o;
  logic signed [VALUE_WIDTH-1:0] best_value_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ADDR_WIDTH-1:0]         paddr;
  logic [DATA_WIDTH-1:0]         pwdata;
  logic [DATA_WIDTH-1:0]         prdata;
  logic                          pready;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned error_count;
  winner_t     expected_winners[$];

  mode_e                         cfg_mode;
  logic [EXTENT_WIDTH:0]         cfg_extent [3];
  logic [OFFSET_WIDTH-1:0]       cfg_stride [4];
  logic signed [VALUE_WIDTH-1:0] lead_value;
  logic [OFFSET_WIDTH-1:0]       lead_offset;
  logic [OFFSET_WIDTH-1:0]       top_offset;
  logic                          have_lead;
  logic [EXTENT_WIDTH:0]         pos_inner;
  logic [EXTENT_WIDTH:0]         pos_middle;
  logic [EXTENT_WIDTH:0]         pos_outer;

  strided_argmin_argmax i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .last_in_set_i (last_in_set_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .best_offset_o (best_offset_o),
    .best_value_o  (best_value_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [EXTENT_WIDTH:0] span_of(input logic [EXTENT_WIDTH:0] e);
    logic [EXTENT_WIDTH:0] lim;
    lim = 1 << EXTENT_WIDTH;
    if (e == 0) begin
      return 1;
    end
    return (e > lim) ? lim : e;
  endfunction

  task automatic clear_set();
    lead_value  = '0;
    lead_offset = '0;
    have_lead   = 1'b0;
    pos_inner   = '0;
    pos_middle  = '0;
    pos_outer   = '0;
    top_offset  = '0;
  endtask

  task automatic track_element(input logic signed [VALUE_WIDTH-1:0] s, input logic l);
    logic [OFFSET_WIDTH-1:0] addr;
    logic                    take;
    addr = top_offset + pos_outer * cfg_stride[2] + pos_middle * cfg_stride[1]
         + pos_inner * cfg_stride[0];
    if (!have_lead) begin
      lead_value  = s;
      lead_offset = '0;
      have_lead   = 1'b1;
    end else begin
      case (cfg_mode)
        MODE_FIRST_MIN: take = s < lead_value;
        MODE_FIRST_MAX: take = s > lead_value;
        MODE_LAST_MIN:  take = s <= lead_value;
        default:        take = s >= lead_value;
      endcase
      if (take) begin
        lead_value  = s;
        lead_offset = addr;
      end
    end
    pos_inner = pos_inner + 1;
    if (pos_inner >= span_of(cfg_extent[0])) begin
      pos_inner  = '0;
      pos_middle = pos_middle + 1;
      if (pos_middle >= span_of(cfg_extent[1])) begin
        pos_middle = '0;
        pos_outer  = pos_outer + 1;
        if (pos_outer >= span_of(cfg_extent[2])) begin
          pos_outer  = '0;
          top_offset = top_offset + cfg_stride[3];
        end
      end
    end
    if (l) begin
      expected_winners.push_back('{offset: lead_offset, value: lead_value});
      clear_set();
    end
  endtask

  task automatic send_item(input logic signed [VALUE_WIDTH-1:0] s, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_i      <= s;
    last_in_set_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    track_element(s, l);
  endtask

  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    while (expected_winners.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_WIDTH-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MODE:          cfg_mode      = mode_e'(data[1:0]);
      REG_EXTENT_INNER:  cfg_extent[0] = data[EXTENT_WIDTH:0];
      REG_EXTENT_MIDDLE: cfg_extent[1] = data[EXTENT_WIDTH:0];
      REG_EXTENT_OUTER:  cfg_extent[2] = data[EXTENT_WIDTH:0];
      REG_STRIDE_INNER:  cfg_stride[0] = data;
      REG_STRIDE_MIDDLE: cfg_stride[1] = data;
      REG_STRIDE_OUTER:  cfg_stride[2] = data;
      default:           cfg_stride[3] = data;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_layout(input logic [DATA_WIDTH-1:0] ei, input logic [DATA_WIDTH-1:0] em,
                              input logic [DATA_WIDTH-1:0] eo, input logic [DATA_WIDTH-1:0] si,
                              input logic [DATA_WIDTH-1:0] sm, input logic [DATA_WIDTH-1:0] so,
                              input logic [DATA_WIDTH-1:0] st);
    write_reg(REG_EXTENT_INNER, ei);
    write_reg(REG_EXTENT_MIDDLE, em);
    write_reg(REG_EXTENT_OUTER, eo);
    write_reg(REG_STRIDE_INNER, si);
    write_reg(REG_STRIDE_MIDDLE, sm);
    write_reg(REG_STRIDE_OUTER, so);
    write_reg(REG_STRIDE_TOP, st);
  endtask

  function automatic logic [DATA_WIDTH-1:0] random_extent();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 15) return 32'hFFFE_0000 | $urandom_range(1, 4);
    if (r < 18) return 32'h0001_0000;
    if (r < 20) return 32'h0001_FFFF;
    return $urandom_range(1, 5);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] random_stride();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 25) return 32'hFFFF_FFFF;
    if (r < 35) return 1;
    if (r < 55) return $urandom_range(2, 64);
    return $urandom;
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] random_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return $urandom;
    if (r < 75) return $signed($urandom_range(0, 6)) - 3;
    if (r < 82) return 32'sh8000_0000;
    if (r < 89) return 32'sh7FFF_FFFF;
    return $signed($urandom_range(0, 6)) - 32'sd2147483645;
  endfunction

  task automatic test_reset_defaults();
    send_item(32'sd42, 1'b1);
    send_item(-32'sd5, 1'b0);
    send_item(32'sd9, 1'b1);
  endtask

  task automatic test_select_modes();
    mode_e m;
    settle_pipeline();
    write_layout(2, 2, 2, 3, 16, 256, 4096);
    for (int k = 0; k < 4; k++) begin
      m = mode_e'(k);
      settle_pipeline();
      write_reg(REG_MODE, {30'h3FFF_FFFF, m});
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sh7FFF_FFFF, 1'b1);
    end
  endtask

  task automatic test_extent_limits();
    settle_pipeline();
    write_layout(32'h0, 32'hFFFE_0002, 32'h0001_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                 32'hFFFF_FFFF, 32'h5);
    write_reg(REG_MODE, 32'hFFFF_FFFF);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(-32'sd7, 1'b0);
    send_item(32'sd1, 1'b1);
  endtask

  task automatic test_random_sets(input int unsigned n_items);
    int unsigned sent;
    int unsigned batch;
    int unsigned set_len;
    sent = 0;
    while (sent < n_items) begin
      settle_pipeline();
      write_reg(REG_MODE, $urandom);
      write_layout(random_extent(), random_extent(), random_extent(), random_stride(),
                   random_stride(), random_stride(), random_stride());
      batch = 0;
      while (batch < 60 && sent < n_items) begin
        set_len = ($urandom_range(9) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 16);
        for (int k = 1; k <= set_len; k++) begin
          send_item(random_sample(), k == set_len);
        end
        sent  += set_len;
        batch += set_len;
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    winner_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_winners.size() == 0) begin
        $error("unexpected result: best_offset %h best_value %0d", best_offset_o, best_value_o);
        error_count++;
      end else begin
        want = expected_winners.pop_front();
        if (best_offset_o !== want.offset) begin
          $error("best_offset expected %h actual %h", want.offset, best_offset_o);
          error_count++;
        end
        if (best_value_o !== want.value) begin
          $error("best_value expected %0d actual %0d", want.value, best_value_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("FAIL strided_argmin_argmax");
    $finish;
  end

  initial begin
    error_count   = 0;
    send_idle_pct = 17;
    recv_idle_pct = 87;
    cfg_mode      = MODE_FIRST_MIN;
    cfg_extent    = '{1, 1, 1};
    cfg_stride    = '{1, 0, 0, 0};
    clear_set();
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    sample_i      <= '0;
    last_in_set_i <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_select_modes();
    test_extent_limits();
    test_random_sets(320);
    send_idle_pct = 87;
    recv_idle_pct = 17;
    test_random_sets(320);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sets(320);

    settle_pipeline();
    if (error_count == 0 && expected_winners.size() == 0) begin
      $display("PASS strided_argmin_argmax");
    end else begin
      $display("FAIL strided_argmin_argmax");
    end
    $finish;
  end

endmodule
